/* rtl/core/jte_pkg.sv */
// Job table engine package: field widths, table size, opcodes, status codes,
// run states and the command record passed from front end to back end.
// No dependencies.
package jte_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int QUEUE_DEPTH   = 2;

    localparam int PID_W = 22;
    localparam int JID_W = 8;
    localparam int RST_W = 2;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_DEL_PID  = 3'd1,
        OP_FIND_PID = 3'd2,
        OP_FIND_JID = 3'd3,
        OP_FG_QUERY = 3'd4,
        OP_STOP_PID = 3'd5,
        OP_RES_PID  = 3'd6,
        OP_RES_JID  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_FULL        = 3'd1,
        STAT_NOT_FOUND   = 3'd2,
        STAT_BAD_ID      = 3'd3,
        STAT_NOT_STOPPED = 3'd4
    } status_t;

    localparam logic [RST_W-1:0] RUN_FREE    = 2'd0;
    localparam logic [RST_W-1:0] RUN_FG      = 2'd1;
    localparam logic [RST_W-1:0] RUN_BG      = 2'd2;
    localparam logic [RST_W-1:0] RUN_STOPPED = 2'd3;

    typedef struct packed {
        op_t              op;
        logic [PID_W-1:0] pid;
        logic [JID_W-1:0] jid;
        logic [RST_W-1:0] new_state;
        logic             bad_id;
    } cmd_t;

endpackage

/* rtl/core/jte_front.sv */
// Front end: registers an incoming transaction, decodes the opcode and flags
// a zero process or job id. Depends on jte_pkg.
module jte_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_opcode,
    input  logic [jte_pkg::PID_W-1:0] s_pid,
    input  logic [jte_pkg::JID_W-1:0] s_job_id,
    input  logic [jte_pkg::RST_W-1:0] s_new_state,
    output logic                     q_valid,
    input  logic                     q_ready,
    output jte_pkg::cmd_t            q_cmd
);
    import jte_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    always_comb begin
        cmd_next           = '0;
        cmd_next.op        = op_t'(s_opcode);
        cmd_next.pid       = s_pid;
        cmd_next.jid       = s_job_id;
        cmd_next.new_state = s_new_state;
        case (op_t'(s_opcode))
            OP_FIND_JID, OP_RES_JID: cmd_next.bad_id = (s_job_id == '0);
            OP_FG_QUERY:             cmd_next.bad_id = 1'b0;
            default:                 cmd_next.bad_id = (s_pid == '0);
        endcase
    end

    assign s_ready = !cmd_valid_reg || q_ready;
    assign q_valid = cmd_valid_reg;
    assign q_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            cmd_valid_reg <= 1'b1;
        end else if (q_ready) begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/core/jte_queue.sv */
// Short command queue between front end and back end.
// Depends on jte_pkg for the command record and depth.
module jte_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  jte_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output jte_pkg::cmd_t out_cmd
);
    import jte_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/core/jte_back.sv */
// Back end: holds the job table and job id counter, scans the table one slot
// a cycle, applies the operation and drives the result register. Depends on jte_pkg.
module jte_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  jte_pkg::cmd_t             q_cmd,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [jte_pkg::PID_W-1:0] m_found_pid,
    output logic [jte_pkg::JID_W-1:0] m_found_jid,
    output logic [jte_pkg::RST_W-1:0] m_found_state
);
    import jte_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MAX,
        ST_DONE
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [SLOT_W-1:0] scan_idx_reg;
    logic [JID_W-1:0]  max_reg;
    logic [JID_W-1:0]  next_jid_reg;

    logic [PID_W-1:0]  ent_pid_reg   [TABLE_ENTRIES];
    logic [JID_W-1:0]  ent_jid_reg   [TABLE_ENTRIES];
    logic [RST_W-1:0]  ent_state_reg [TABLE_ENTRIES];

    status_t           res_status_reg;
    logic [PID_W-1:0]  res_pid_reg;
    logic [JID_W-1:0]  res_jid_reg;
    logic [RST_W-1:0]  res_state_reg;

    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [PID_W-1:0]  m_pid_reg;
    logic [JID_W-1:0]  m_jid_reg;
    logic [RST_W-1:0]  m_state_reg;

    logic [PID_W-1:0]  rd_pid;
    logic [JID_W-1:0]  rd_jid;
    logic [RST_W-1:0]  rd_state;
    logic              scan_hit;
    logic              scan_last;
    logic              out_load;
    logic [JID_W:0]    jid_inc;
    logic [JID_W-1:0]  next_jid_next;
    logic [JID_W-1:0]  max_next;

    assign rd_pid    = ent_pid_reg[scan_idx_reg];
    assign rd_jid    = ent_jid_reg[scan_idx_reg];
    assign rd_state  = ent_state_reg[scan_idx_reg];
    assign scan_last = (scan_idx_reg == SLOT_W'(TABLE_ENTRIES - 1));
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        case (cmd_reg.op)
            OP_ADD:                  scan_hit = (rd_pid == '0);
            OP_FIND_JID, OP_RES_JID: scan_hit = (rd_jid == cmd_reg.jid);
            OP_FG_QUERY:             scan_hit = (rd_state == RUN_FG);
            default:                 scan_hit = (rd_pid == cmd_reg.pid);
        endcase
    end

    // add: counter steps and falls back to 1 past the table size
    assign jid_inc       = {1'b0, next_jid_reg} + 1'b1;
    assign next_jid_next = (jid_inc > (JID_W + 1)'(TABLE_ENTRIES)) ?
                           JID_W'(1) : jid_inc[JID_W-1:0];
    assign max_next      = (rd_jid > max_reg) ? rd_jid : max_reg;

    assign q_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_pid   = m_pid_reg;
    assign m_found_jid   = m_jid_reg;
    assign m_found_state = m_state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            next_jid_reg <= JID_W'(1);
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                ent_pid_reg[i]   <= '0;
                ent_jid_reg[i]   <= '0;
                ent_state_reg[i] <= RUN_FREE;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg      <= q_cmd;
                        scan_idx_reg <= '0;
                        if (q_cmd.bad_id) begin
                            res_status_reg <= STAT_BAD_ID;
                            res_pid_reg    <= '0;
                            res_jid_reg    <= '0;
                            res_state_reg  <= RUN_FREE;
                            state_reg      <= ST_DONE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_hit) begin
                        case (cmd_reg.op)
                            OP_ADD: begin
                                ent_pid_reg[scan_idx_reg]   <= cmd_reg.pid;
                                ent_jid_reg[scan_idx_reg]   <= next_jid_reg;
                                ent_state_reg[scan_idx_reg] <= cmd_reg.new_state;
                                res_status_reg              <= STAT_OK;
                                res_pid_reg                 <= cmd_reg.pid;
                                res_jid_reg                 <= next_jid_reg;
                                res_state_reg               <= cmd_reg.new_state;
                                next_jid_reg                <= next_jid_next;
                                state_reg                   <= ST_DONE;
                            end
                            OP_DEL_PID: begin
                                // report before clearing, then rescan for the top id
                                res_status_reg              <= STAT_OK;
                                res_pid_reg                 <= rd_pid;
                                res_jid_reg                 <= rd_jid;
                                res_state_reg               <= rd_state;
                                ent_pid_reg[scan_idx_reg]   <= '0;
                                ent_jid_reg[scan_idx_reg]   <= '0;
                                ent_state_reg[scan_idx_reg] <= RUN_FREE;
                                max_reg                     <= '0;
                                scan_idx_reg                <= '0;
                                state_reg                   <= ST_MAX;
                            end
                            OP_STOP_PID: begin
                                ent_state_reg[scan_idx_reg] <= RUN_STOPPED;
                                res_status_reg              <= STAT_OK;
                                res_pid_reg                 <= rd_pid;
                                res_jid_reg                 <= rd_jid;
                                res_state_reg               <= RUN_STOPPED;
                                state_reg                   <= ST_DONE;
                            end
                            OP_RES_PID, OP_RES_JID: begin
                                res_pid_reg <= rd_pid;
                                res_jid_reg <= rd_jid;
                                state_reg   <= ST_DONE;
                                if (rd_state != RUN_STOPPED) begin
                                    res_status_reg <= STAT_NOT_STOPPED;
                                    res_state_reg  <= rd_state;
                                end else begin
                                    ent_state_reg[scan_idx_reg] <= cmd_reg.new_state;
                                    res_status_reg              <= STAT_OK;
                                    res_state_reg               <= cmd_reg.new_state;
                                end
                            end
                            default: begin
                                res_status_reg <= STAT_OK;
                                res_pid_reg    <= rd_pid;
                                res_jid_reg    <= rd_jid;
                                res_state_reg  <= rd_state;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end else if (scan_last) begin
                        res_status_reg <= (cmd_reg.op == OP_ADD) ? STAT_FULL : STAT_NOT_FOUND;
                        res_pid_reg    <= '0;
                        res_jid_reg    <= '0;
                        res_state_reg  <= RUN_FREE;
                        state_reg      <= ST_DONE;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_MAX: begin
                    max_reg <= max_next;
                    if (scan_last) begin
                        next_jid_reg <= max_next + 1'b1;
                        state_reg    <= ST_DONE;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_status_reg <= res_status_reg;
                        m_pid_reg    <= res_pid_reg;
                        m_jid_reg    <= res_jid_reg;
                        m_state_reg  <= res_state_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_hit_leaves_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_hit) |=> (state_reg == ST_DONE || state_reg == ST_MAX))
        else $error("scan hit did not end the scan");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result stage overwritten while stalled");

    a_taken_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && state_reg != ST_DONE) |=> !m_valid_reg)
        else $error("result repeated after transaction");

    a_bad_id_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_valid && q_cmd.bad_id)
        |=> (state_reg == ST_DONE && res_status_reg == STAT_BAD_ID))
        else $error("zero id not reported at once");

endmodule

/* rtl/core/job_table_engine_unit.sv */
// Job table engine top level: front end, command queue and back end.
// Depends on jte_pkg, jte_front, jte_queue and jte_back.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | opcode, pid, job_id, new_state
//  m_      | out       | m_valid / m_ready | status, found_pid, found_jid, found_state
//
// A zero id is answered without a scan, straight from the back end's idle state to
// its done state; a scan operation reads the table one slot at a time up to the
// first hit or the last slot, and a delete adds a rescan of all TABLE_ENTRIES slots
// for the largest job id. The two-deep queue lets the front end take commands
// meanwhile. Reset is synchronous, active low, and clears the table; a stalled
// result holds the back end in its done state.
module job_table_engine_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_opcode,
    input  logic [jte_pkg::PID_W-1:0] s_pid,
    input  logic [jte_pkg::JID_W-1:0] s_job_id,
    input  logic [jte_pkg::RST_W-1:0] s_new_state,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [jte_pkg::PID_W-1:0] m_found_pid,
    output logic [jte_pkg::JID_W-1:0] m_found_jid,
    output logic [jte_pkg::RST_W-1:0] m_found_state
);
    import jte_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    jte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_pid       (s_pid),
        .s_job_id    (s_job_id),
        .s_new_state (s_new_state),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_cmd       (fq_cmd)
    );

    jte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    jte_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_cmd         (qb_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_pid   (m_found_pid),
        .m_found_jid   (m_found_jid),
        .m_found_state (m_found_state)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for job_table_engine_unit: directed and random job commands,
// with an in-bench job table that predicts every reply.
// Depends on jte_pkg and the job_table_engine_unit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jte_pkg::*;

    typedef struct packed {
        op_t              op;
        logic [PID_W-1:0] pid;
        logic [JID_W-1:0] jid;
        logic [RST_W-1:0] ns;
    } job_cmd_t;

    typedef struct packed {
        status_t          status;
        logic [PID_W-1:0] pid;
        logic [JID_W-1:0] jid;
        logic [RST_W-1:0] state;
    } job_reply_t;

    localparam int RANDOM_CMDS = 1150;
    localparam int POOL_SIZE   = 24;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [2:0]          s_opcode    = '0;
    logic [PID_W-1:0]    s_pid       = '0;
    logic [JID_W-1:0]    s_job_id    = '0;
    logic [RST_W-1:0]    s_new_state = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [2:0]          m_status;
    logic [PID_W-1:0]    m_found_pid;
    logic [JID_W-1:0]    m_found_jid;
    logic [RST_W-1:0]    m_found_state;

    job_table_engine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_pid         (s_pid),
        .s_job_id      (s_job_id),
        .s_new_state   (s_new_state),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_pid   (m_found_pid),
        .m_found_jid   (m_found_jid),
        .m_found_state (m_found_state)
    );

    always #5 aclk = ~aclk;

    // shadow job table
    logic [PID_W-1:0] tab_pid [TABLE_ENTRIES];
    logic [JID_W-1:0] tab_jid [TABLE_ENTRIES];
    logic [RST_W-1:0] tab_st  [TABLE_ENTRIES];
    logic [JID_W-1:0] next_jid;

    job_cmd_t   pending_cmds[$];
    job_reply_t expected_replies[$];
    job_cmd_t   cur_cmd;
    int         n_accepted = 0;
    int         n_errors   = 0;
    int         status_seen[5];
    logic       calm;

    // no idling on either side over a stretch of the run
    assign calm = (n_accepted >= 500) && (n_accepted < 700);

    function automatic int slot_of_pid(logic [PID_W-1:0] p);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tab_pid[i] == p) return i;
        end
        return -1;
    endfunction

    function automatic int slot_of_jid(logic [JID_W-1:0] j);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tab_jid[i] == j) return i;
        end
        return -1;
    endfunction

    function automatic job_reply_t reply_from(status_t st, int slot);
        job_reply_t r;
        r = '{status: st, pid: '0, jid: '0, state: '0};
        if (slot >= 0) begin
            r.pid   = tab_pid[slot];
            r.jid   = tab_jid[slot];
            r.state = tab_st[slot];
        end
        return r;
    endfunction

    function automatic job_reply_t predict_job_op(job_cmd_t c);
        job_reply_t       r;
        int               slot;
        logic [8:0]       nj;
        logic [JID_W-1:0] top;
        slot = -1;
        top  = '0;
        if (c.op inside {OP_FIND_JID, OP_RES_JID} ? (c.jid == 0) :
            (c.op != OP_FG_QUERY && c.pid == 0)) begin
            r = reply_from(STAT_BAD_ID, -1);
        end else begin
            case (c.op)
                OP_ADD: begin
                    slot = slot_of_pid('0);
                    if (slot < 0) begin
                        r = reply_from(STAT_FULL, -1);
                    end else begin
                        tab_pid[slot] = c.pid;
                        tab_st[slot]  = c.ns;
                        tab_jid[slot] = next_jid;
                        nj = {1'b0, next_jid} + 9'd1;
                        if (nj > TABLE_ENTRIES) nj = 9'd1;
                        next_jid = nj[JID_W-1:0];
                        r = reply_from(STAT_OK, slot);
                    end
                end
                OP_DEL_PID: begin
                    slot = slot_of_pid(c.pid);
                    if (slot < 0) begin
                        r = reply_from(STAT_NOT_FOUND, -1);
                    end else begin
                        // reply carries the entry as it was before clearing
                        r = reply_from(STAT_OK, slot);
                        tab_pid[slot] = '0;
                        tab_jid[slot] = '0;
                        tab_st[slot]  = RUN_FREE;
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (tab_jid[i] > top) top = tab_jid[i];
                        end
                        next_jid = top + 8'd1;
                    end
                end
                default: begin
                    if (c.op == OP_FG_QUERY) begin
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (slot < 0 && tab_st[i] == RUN_FG) slot = i;
                        end
                    end else if (c.op == OP_FIND_JID || c.op == OP_RES_JID) begin
                        slot = slot_of_jid(c.jid);
                    end else begin
                        slot = slot_of_pid(c.pid);
                    end
                    if (slot < 0) begin
                        r = reply_from(STAT_NOT_FOUND, -1);
                    end else if (c.op == OP_STOP_PID) begin
                        tab_st[slot] = RUN_STOPPED;
                        r = reply_from(STAT_OK, slot);
                    end else if ((c.op == OP_RES_PID || c.op == OP_RES_JID) &&
                                 tab_st[slot] != RUN_STOPPED) begin
                        r = reply_from(STAT_NOT_STOPPED, slot);
                    end else begin
                        if (c.op == OP_RES_PID || c.op == OP_RES_JID) tab_st[slot] = c.ns;
                        r = reply_from(STAT_OK, slot);
                    end
                end
            endcase
        end
        status_seen[r.status]++;
        return r;
    endfunction

    // driver: one transaction held until accepted, then the next from the queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_replies.push_back(predict_job_op(cur_cmd));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_valid     <= 1'b1;
                    s_opcode    <= cur_cmd.op;
                    s_pid       <= cur_cmd.pid;
                    s_job_id    <= cur_cmd.jid;
                    s_new_state <= cur_cmd.ns;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, replies checked in order
    always @(posedge aclk) begin
        job_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with no command outstanding: status %0d pid %0h",
                           m_status, m_found_pid);
                    n_errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        n_errors++;
                    end
                    if (m_found_pid !== want.pid) begin
                        $error("found_pid: expected %0h, got %0h", want.pid, m_found_pid);
                        n_errors++;
                    end
                    if (m_found_jid !== want.jid) begin
                        $error("found_jid: expected %0d, got %0d", want.jid, m_found_jid);
                        n_errors++;
                    end
                    if (m_found_state !== want.state) begin
                        $error("found_state: expected %0d, got %0d",
                               want.state, m_found_state);
                        n_errors++;
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    task automatic queue_cmd(op_t op, logic [PID_W-1:0] p, logic [JID_W-1:0] j,
                             logic [RST_W-1:0] ns);
        pending_cmds.push_back('{op: op, pid: p, jid: j, ns: ns});
    endtask

    initial begin
        logic [PID_W-1:0] pid_pool [POOL_SIZE];
        logic [PID_W-1:0] p;
        logic [JID_W-1:0] j;
        op_t              op;
        int               roll;
        bit               filling;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tab_pid[i] = '0;
            tab_jid[i] = '0;
            tab_st[i]  = RUN_FREE;
        end
        next_jid = 8'd1;
        foreach (status_seen[i]) status_seen[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pid_pool[i] = PID_W'($urandom_range(22'h3FFFFF, 1));
        end

        // directed: zero ids, empty table, running and stopped jobs
        queue_cmd(OP_FG_QUERY, '0, '0, RUN_FG);
        queue_cmd(OP_ADD,      '0, '0, RUN_FG);
        queue_cmd(OP_DEL_PID,  '0, '0, RUN_FG);
        queue_cmd(OP_FIND_PID, '0, '0, RUN_FG);
        queue_cmd(OP_STOP_PID, '0, '0, RUN_FG);
        queue_cmd(OP_RES_PID,  '0, '0, RUN_FG);
        queue_cmd(OP_FIND_JID, '0, '0, RUN_FG);
        queue_cmd(OP_RES_JID,  '0, '0, RUN_FG);
        queue_cmd(OP_ADD,      22'h3FFFFF, 8'hFF, RUN_FG);
        queue_cmd(OP_FIND_JID, '0, 8'd1, RUN_FG);
        queue_cmd(OP_FG_QUERY, '0, '0, RUN_FG);
        queue_cmd(OP_RES_JID,  '0, 8'd1, RUN_BG);
        queue_cmd(OP_STOP_PID, 22'h3FFFFF, '0, RUN_FG);
        // resume into the odd free-looking state keeps the slot occupied
        queue_cmd(OP_RES_PID,  22'h3FFFFF, '0, RUN_FREE);
        queue_cmd(OP_FIND_PID, 22'h3FFFFF, '0, RUN_FG);
        queue_cmd(OP_FIND_JID, '0, 8'hFF, RUN_FG);
        queue_cmd(OP_DEL_PID,  22'h155555, '0, RUN_FG);
        for (int k = 1; k < TABLE_ENTRIES; k++) begin
            queue_cmd(OP_ADD, 22'h2AAAAA ^ PID_W'(k), '0, RST_W'(k));
        end
        queue_cmd(OP_ADD,      22'h000001, '0, RUN_FG);
        queue_cmd(OP_DEL_PID,  22'h3FFFFF, '0, RUN_FG);
        queue_cmd(OP_ADD,      22'h000001, '0, RUN_STOPPED);
        queue_cmd(OP_RES_JID,  '0, 8'd17, RUN_FG);

        // random: alternating fill and drain phases over a small pool of pids
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            filling = ((n / 40) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < (filling ? 45 : 10))      op = OP_ADD;
            else if (roll < (filling ? 55 : 45)) op = OP_DEL_PID;
            else                                 op = op_t'($urandom_range(7, 2));
            roll = $urandom_range(99);
            if (roll < 85)      p = pid_pool[$urandom_range(POOL_SIZE-1)];
            else if (roll < 96) p = PID_W'($urandom_range(22'h3FFFFF));
            else                p = '0;
            roll = $urandom_range(99);
            if (roll < 85)      j = JID_W'($urandom_range(TABLE_ENTRIES+1, 1));
            else if (roll < 97) j = JID_W'($urandom_range(255));
            else                j = '0;
            queue_cmd(op, p, j, RST_W'($urandom_range(3)));
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_replies.size() != 0);
        // catch any stray reply after the last one
        repeat (60) @(posedge aclk);

        $display("%0d commands checked: %0d ok, %0d table full, %0d not found,",
                 n_accepted, status_seen[STAT_OK], status_seen[STAT_FULL],
                 status_seen[STAT_NOT_FOUND]);
        $display("  %0d zero id, %0d resume of a running job",
                 status_seen[STAT_BAD_ID], status_seen[STAT_NOT_STOPPED]);
        if (n_errors == 0 && expected_replies.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

endmodule
